// File: rtl/frc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, constants and helpers of the frame repair cache.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int FRAMES  = 16;
    localparam int IDX_W   = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 2);
    localparam int STREAMS = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES + 1);
    localparam logic [CNT_W-1:0] CNT_PROC = CNT_W'(FRAMES);

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] REG_MAX_AGE    = 2'd0;
    localparam logic [1:0] REG_STREAM_CAP = 2'd1;
    localparam logic [1:0] REG_TOTAL_CAP  = 2'd2;

    // scope code of a candidate search that spans all streams
    localparam logic [1:0] SCOPE_ALL = 2'd3;

    typedef enum logic [1:0] {
        KIND_EVICT = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_HIT   = 2'd2,
        KIND_MISS  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  stream;
        logic [31:0] seq;
        logic [31:0] bytes;
        logic        keyframe;
        logic [62:0] stamp;
        logic [63:0] order;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [1:0]       stream;
        logic [31:0]      seq;
        logic [31:0]      bytes;
        logic             keyframe;
        logic [63:0]      order;
    } cand_t;

    typedef struct packed {
        logic signed [47:0] max_age;
        logic [31:0]        stream_cap;
        logic [31:0]        total_cap;
    } cfg_t;

    typedef struct packed {
        logic        strobe;
        kind_t       kind;
        logic [1:0]  stream;
        logic [31:0] seq;
        logic [31:0] bytes;
        logic        keyframe;
        logic        last;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LU_SCAN,
        S_LU_EMIT,
        S_FIND_SCAN,
        S_FIND_DROP,
        S_ROOM,
        S_FULL_LK,
        S_FULL_CAND,
        S_FULL_EVICT,
        S_INSERT,
        S_SEL_SCAN,
        S_EXP_SCAN,
        S_EXP_EVICT,
        S_CAP_CHECK,
        S_CAP_LK,
        S_CAP_CAND,
        S_CAP_EVICT,
        S_ALL_SCAN,
        S_ALL_EVICT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        SK_NONE,
        SK_FIND,
        SK_LK,
        SK_CAND,
        SK_SEL,
        SK_MIN
    } scan_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
        return (b >= a) ? 32'd0 : (a - b);
    endfunction

    function automatic cand_t make_cand(input logic [IDX_W-1:0] idx, input entry_t e);
        cand_t c;
        c.idx      = idx;
        c.stream   = e.stream;
        c.seq      = e.seq;
        c.bytes    = e.bytes;
        c.keyframe = e.keyframe;
        c.order    = e.order;
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/frc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc_mem
// Entry table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frc_mem
    import frc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [FRAMES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/frc_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc_seq
// Command sequencer: table scans, candidate search, eviction and insert.
// ----------------------------------------------------------------------------
module frc_seq
    import frc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [1:0]  stream,
    input  logic [31:0] frame_seq,
    input  logic [31:0] frame_bytes,
    input  logic        is_keyframe,
    input  logic [62:0] now,
    output result_t     res
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cmd_reg, cmd_next;
    logic [1:0]        stream_reg, stream_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic              kf_reg, kf_next;
    logic [62:0]       now_reg, now_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] sel_reg, sel_next;
    cand_t             a_reg, a_next;
    logic              a_ok_reg, a_ok_next;
    cand_t             b_reg, b_next;
    logic              b_ok_reg, b_ok_next;
    logic [STREAMS-1:0] lk_ok_reg, lk_ok_next;
    logic [IDX_W-1:0]  lk_idx_reg [STREAMS];
    logic [IDX_W-1:0]  lk_idx_next [STREAMS];
    logic [63:0]       lk_ord_reg [STREAMS];
    logic [63:0]       lk_ord_next [STREAMS];
    logic [31:0]       ssum_reg [STREAMS];
    logic [31:0]       ssum_next [STREAMS];
    logic [31:0]       tsum_reg, tsum_next;
    logic [63:0]       order_reg, order_next;
    logic [2:0]        scope_reg, scope_next;
    logic              any_reg, any_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            e;

    scan_t             scan_kind;
    logic [1:0]        cand_scope;
    logic [FRAMES-1:0] min_mask;
    logic              proc;
    logic              scan_end;
    logic [IDX_W-1:0]  pi;
    logic [IDX_W-1:0]  free_idx;
    logic              do_drop;
    logic              in_scope;
    logic              prot;
    logic [62:0]       age;

    frc_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (e)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= '0;
            a_ok_reg  <= 1'b0;
            b_ok_reg  <= 1'b0;
            lk_ok_reg <= '0;
            tsum_reg  <= '0;
            order_reg <= '0;
            scope_reg <= '0;
            any_reg   <= 1'b0;
            for (int s = 0; s < STREAMS; s++)
            begin
                ssum_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            a_ok_reg  <= a_ok_next;
            b_ok_reg  <= b_ok_next;
            lk_ok_reg <= lk_ok_next;
            tsum_reg  <= tsum_next;
            order_reg <= order_next;
            scope_reg <= scope_next;
            any_reg   <= any_next;
            for (int s = 0; s < STREAMS; s++)
            begin
                ssum_reg[s] <= ssum_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        stream_reg <= stream_next;
        seq_reg    <= seq_next;
        bytes_reg  <= bytes_next;
        kf_reg     <= kf_next;
        now_reg    <= now_next;
        sel_reg    <= sel_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        for (int s = 0; s < STREAMS; s++)
        begin
            lk_idx_reg[s] <= lk_idx_next[s];
            lk_ord_reg[s] <= lk_ord_next[s];
        end
    end

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign proc      = (cnt_reg != '0) && (cnt_reg <= CNT_PROC);
    assign scan_end  = (cnt_reg == CNT_LAST);
    assign pi        = IDX_W'(cnt_reg - CNT_W'(1));
    assign mem_raddr = (cnt_reg < CNT_PROC) ? cnt_reg[IDX_W-1:0] : '0;
    assign busy      = (state_reg != S_IDLE);
    assign age       = now_reg - e.stamp;

    always_comb
    begin
        unique case (state_reg)
            S_LU_SCAN, S_FIND_SCAN:  scan_kind = SK_FIND;
            S_FULL_LK, S_CAP_LK:     scan_kind = SK_LK;
            S_FULL_CAND, S_CAP_CAND: scan_kind = SK_CAND;
            S_SEL_SCAN:              scan_kind = SK_SEL;
            S_EXP_SCAN, S_ALL_SCAN:  scan_kind = SK_MIN;
            default:                 scan_kind = SK_NONE;
        endcase
    end

    assign cand_scope = (state_reg == S_FULL_CAND) ? SCOPE_ALL : scope_reg[1:0];
    assign min_mask   = (state_reg == S_EXP_SCAN) ? sel_reg : {FRAMES{1'b1}};

    always_comb
    begin
        in_scope = (cand_scope == SCOPE_ALL) || (e.stream == cand_scope);
        prot     = 1'b0;
        for (int s = 0; s < STREAMS; s++)
        begin
            if (e.stream == 2'(s) && lk_ok_reg[s] && lk_idx_reg[s] == pi)
            begin
                prot = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        stream_next = stream_reg;
        seq_next    = seq_reg;
        bytes_next  = bytes_reg;
        kf_next     = kf_reg;
        now_next    = now_reg;
        valid_next  = valid_reg;
        sel_next    = sel_reg;
        a_next      = a_reg;
        a_ok_next   = a_ok_reg;
        b_next      = b_reg;
        b_ok_next   = b_ok_reg;
        lk_ok_next  = lk_ok_reg;
        for (int s = 0; s < STREAMS; s++)
        begin
            lk_idx_next[s] = lk_idx_reg[s];
            lk_ord_next[s] = lk_ord_reg[s];
            ssum_next[s]   = ssum_reg[s];
        end
        tsum_next  = tsum_reg;
        order_next = order_reg;
        scope_next = scope_reg;
        any_next   = any_reg;
        do_drop    = 1'b0;
        res        = '0;
        res.kind   = KIND_EVICT;
        mem_we     = 1'b0;
        mem_waddr  = free_idx;
        mem_wdata.stream   = stream_reg;
        mem_wdata.seq      = seq_reg;
        mem_wdata.bytes    = bytes_reg;
        mem_wdata.keyframe = kf_reg;
        mem_wdata.stamp    = now_reg;
        mem_wdata.order    = order_reg;

        // scan datapath: one entry per cycle, data in the cycle after its address
        if (scan_kind != SK_NONE)
        begin
            cnt_next = scan_end ? '0 : cnt_reg + CNT_W'(1);
            if (cnt_reg == '0)
            begin
                a_ok_next = 1'b0;
                b_ok_next = 1'b0;
                if (scan_kind == SK_LK)
                begin
                    lk_ok_next = '0;
                end
            end
            if (proc)
            begin
                case (scan_kind)
                    SK_FIND:
                    begin
                        if (valid_reg[pi] && e.stream == stream_reg && e.seq == seq_reg)
                        begin
                            a_ok_next = 1'b1;
                            a_next    = make_cand(pi, e);
                        end
                    end
                    SK_LK:
                    begin
                        for (int s = 0; s < STREAMS; s++)
                        begin
                            if (valid_reg[pi] && e.keyframe && e.stream == 2'(s) &&
                                (!lk_ok_reg[s] || e.order > lk_ord_reg[s]))
                            begin
                                lk_ok_next[s]  = 1'b1;
                                lk_idx_next[s] = pi;
                                lk_ord_next[s] = e.order;
                            end
                        end
                    end
                    SK_CAND:
                    begin
                        if (valid_reg[pi] && in_scope)
                        begin
                            if (!a_ok_reg || e.order < a_reg.order)
                            begin
                                a_ok_next = 1'b1;
                                a_next    = make_cand(pi, e);
                            end
                            if (!prot && (!b_ok_reg || e.order < b_reg.order))
                            begin
                                b_ok_next = 1'b1;
                                b_next    = make_cand(pi, e);
                            end
                        end
                    end
                    SK_SEL:
                    begin
                        sel_next[pi] = valid_reg[pi] && (now_reg >= e.stamp) &&
                                       (age > {16'd0, cfg.max_age[46:0]});
                    end
                    SK_MIN:
                    begin
                        if (valid_reg[pi] && min_mask[pi] &&
                            (!a_ok_reg || {e.stream, e.seq} < {a_reg.stream, a_reg.seq}))
                        begin
                            a_ok_next = 1'b1;
                            a_next    = make_cand(pi, e);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    cmd_next    = cmd;
                    stream_next = stream;
                    seq_next    = frame_seq;
                    bytes_next  = frame_bytes;
                    kf_next     = is_keyframe;
                    now_next    = now;
                    if (cmd == CMD_LOOKUP)
                    begin
                        state_next = S_LU_SCAN;
                    end
                    else if (stream == SCOPE_ALL)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIND_SCAN;
                    end
                end
            end
            S_LU_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_LU_EMIT;
                end
            end
            S_LU_EMIT:
            begin
                res.strobe = 1'b1;
                res.last   = 1'b1;
                if (a_ok_reg)
                begin
                    res.kind     = KIND_HIT;
                    res.stream   = a_reg.stream;
                    res.seq      = a_reg.seq;
                    res.bytes    = a_reg.bytes;
                    res.keyframe = a_reg.keyframe;
                end
                else
                begin
                    res.kind = KIND_MISS;
                end
                state_next = S_IDLE;
            end
            S_FIND_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = a_ok_reg ? S_FIND_DROP : S_ROOM;
                end
            end
            S_FIND_DROP:
            begin
                do_drop    = 1'b1;
                state_next = S_ROOM;
            end
            S_ROOM:
            begin
                state_next = (&valid_reg) ? S_FULL_LK : S_INSERT;
            end
            S_FULL_LK:
            begin
                if (scan_end)
                begin
                    state_next = S_FULL_CAND;
                end
            end
            S_FULL_CAND:
            begin
                if (scan_end)
                begin
                    if (b_ok_reg)
                    begin
                        a_next = b_reg;
                    end
                    state_next = S_FULL_EVICT;
                end
            end
            S_FULL_EVICT:
            begin
                res.strobe = 1'b1;
                do_drop    = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                mem_we            = 1'b1;
                valid_next[free_idx] = 1'b1;
                order_next        = order_reg + 64'd1;
                tsum_next         = sat_add(tsum_reg, bytes_reg);
                for (int s = 0; s < STREAMS; s++)
                begin
                    if (stream_reg == 2'(s))
                    begin
                        ssum_next[s] = sat_add(ssum_reg[s], bytes_reg);
                    end
                end
                scope_next = '0;
                any_next   = 1'b0;
                state_next = cfg.max_age[47] ? S_CAP_CHECK : S_SEL_SCAN;
            end
            S_SEL_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_EXP_SCAN;
                end
            end
            S_EXP_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = a_ok_reg ? S_EXP_EVICT : S_CAP_CHECK;
                end
            end
            S_EXP_EVICT:
            begin
                res.strobe = 1'b1;
                do_drop    = 1'b1;
                state_next = S_EXP_SCAN;
            end
            S_CAP_CHECK:
            begin
                if (scope_reg < 3'd3)
                begin
                    if (cfg.stream_cap == '0 || ssum_reg[scope_reg[1:0]] > cfg.stream_cap)
                    begin
                        state_next = S_CAP_LK;
                    end
                    else
                    begin
                        scope_next = scope_reg + 3'd1;
                    end
                end
                else if (scope_reg == 3'd3)
                begin
                    if (cfg.total_cap == '0)
                    begin
                        state_next = S_ALL_SCAN;
                    end
                    else if (tsum_reg > cfg.total_cap)
                    begin
                        state_next = S_CAP_LK;
                    end
                    else
                    begin
                        scope_next = 3'd4;
                    end
                end
                else
                begin
                    // end of a round: repeat while anything went out
                    if (any_reg)
                    begin
                        any_next   = 1'b0;
                        scope_next = '0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CAP_LK:
            begin
                if (scan_end)
                begin
                    state_next = S_CAP_CAND;
                end
            end
            S_CAP_CAND:
            begin
                if (scan_end)
                begin
                    if (b_ok_reg || a_ok_reg)
                    begin
                        if (b_ok_reg)
                        begin
                            a_next = b_reg;
                        end
                        state_next = S_CAP_EVICT;
                    end
                    else
                    begin
                        scope_next = scope_reg + 3'd1;
                        state_next = S_CAP_CHECK;
                    end
                end
            end
            S_CAP_EVICT:
            begin
                res.strobe = 1'b1;
                do_drop    = 1'b1;
                any_next   = 1'b1;
                state_next = S_CAP_CHECK;
            end
            S_ALL_SCAN:
            begin
                if (scan_end)
                begin
                    if (a_ok_reg)
                    begin
                        state_next = S_ALL_EVICT;
                    end
                    else
                    begin
                        scope_next = 3'd4;
                        state_next = S_CAP_CHECK;
                    end
                end
            end
            S_ALL_EVICT:
            begin
                res.strobe = 1'b1;
                do_drop    = 1'b1;
                any_next   = 1'b1;
                state_next = S_ALL_SCAN;
            end
            S_DONE:
            begin
                res.strobe = 1'b1;
                res.kind   = KIND_DONE;
                res.last   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // eviction words carry the chosen entry
        if (res.strobe && res.kind == KIND_EVICT)
        begin
            res.stream   = a_reg.stream;
            res.seq      = a_reg.seq;
            res.bytes    = a_reg.bytes;
            res.keyframe = a_reg.keyframe;
        end

        if (do_drop)
        begin
            valid_next[a_reg.idx] = 1'b0;
            tsum_next = floor_sub(tsum_reg, a_reg.bytes);
            for (int s = 0; s < STREAMS; s++)
            begin
                if (a_reg.stream == 2'(s))
                begin
                    ssum_next[s] = floor_sub(ssum_reg[s], a_reg.bytes);
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/frame_repair_cache_eviction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_repair_cache_eviction
// Cache table of video frames with replace, expiry and byte-cap eviction.
// ----------------------------------------------------------------------------
// Scans: a table scan walks every entry through the single read port and
//   every word passes one output register. A store costs a find scan, then
//   per eviction two scans (keyframe and candidate; also per cap pass that
//   finds nothing) or one for expiry and a zero global cap, plus a selection
//   and a closing scan when expiry is on.
// Throughput: one command at a time; busy drops as the last word enters the
//   output register, so the next command may be taken while that word is out.
// Reset clears the valid bits, byte sums, insertion counter and result strobe
// at once; result words cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module frame_repair_cache_eviction
    import frc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [1:0]        stream,
    input  logic [31:0]       frame_seq,
    input  logic [31:0]       frame_bytes,
    input  logic              is_keyframe,
    input  logic [62:0]       now,
    // result channel
    output logic              strobe,
    output logic [1:0]        kind,
    output logic [1:0]        out_stream,
    output logic [31:0]       out_seq,
    output logic [31:0]       out_bytes,
    output logic              out_keyframe,
    output logic              last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg_reg, cfg_next;
    result_t res;
    result_t res_reg;
    logic    cfg_wr;

    // Registers sit on 8-byte boundaries; address bits above the low three
    // select the register.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_MAX_AGE:    cfg_next.max_age    = pwdata[47:0];
                REG_STREAM_CAP: cfg_next.stream_cap = pwdata[31:0];
                REG_TOTAL_CAP:  cfg_next.total_cap  = pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age    <= '1;
            cfg_reg.stream_cap <= '0;
            cfg_reg.total_cap  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back; the age limit returns sign-extended
    always_comb
    begin
        unique case (paddr[4:3])
            REG_MAX_AGE:    prdata = {{16{cfg_reg.max_age[47]}}, cfg_reg.max_age};
            REG_STREAM_CAP: prdata = {32'd0, cfg_reg.stream_cap};
            REG_TOTAL_CAP:  prdata = {32'd0, cfg_reg.total_cap};
            default:        prdata = '0;
        endcase
    end

    frc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .stream      (stream),
        .frame_seq   (frame_seq),
        .frame_bytes (frame_bytes),
        .is_keyframe (is_keyframe),
        .now         (now),
        .res         (res)
    );

    // Hold each word for one cycle in the output register; clear it on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res;
        end
    end

    assign strobe       = res_reg.strobe;
    assign kind         = res_reg.kind;
    assign out_stream   = res_reg.stream;
    assign out_seq      = res_reg.seq;
    assign out_bytes    = res_reg.bytes;
    assign out_keyframe = res_reg.keyframe;
    assign last         = res_reg.last;

endmodule
`default_nettype wire

// File: dv/frame_repair_cache_eviction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_repair_cache_eviction_tb
// Drives store and lookup commands into the frame cache under several age and
// byte-cap settings, predicts every eviction, done, hit and miss word from a
// shadow copy of the table, and checks each result word field by field.
// ----------------------------------------------------------------------------
module frame_repair_cache_eviction_tb
    import frc_pkg::*;
();

    // one expected result word
    typedef struct {
        kind_t       kind;
        logic [1:0]  stream;
        logic [31:0] seq;
        logic [31:0] bytes;
        logic        keyframe;
        logic        last;
    } cache_word_t;

    // Shadow of the frame table: computes the words each command causes and
    // holds them until the block delivers them.
    class frame_table_predictor;
        bit          valid [FRAMES];
        bit [1:0]    ent_stream [FRAMES];
        bit [31:0]   ent_seq [FRAMES];
        bit [31:0]   ent_bytes [FRAMES];
        bit          ent_kf [FRAMES];
        bit [63:0]   ent_stamp [FRAMES];
        bit [63:0]   ent_order [FRAMES];
        bit          pick [FRAMES];
        bit [31:0]   stream_sum [STREAMS];
        bit [31:0]   total_sum;
        bit [63:0]   order_ctr;
        longint      age_limit;
        bit [31:0]   stream_cap;
        bit [31:0]   total_cap;
        cache_word_t pending [$];
        int          errors;

        function new();
            foreach (valid[i]) valid[i] = 0;
            foreach (stream_sum[s]) stream_sum[s] = 0;
            total_sum  = 0;
            order_ctr  = 0;
            age_limit  = -1;
            stream_cap = 0;
            total_cap  = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            if (idx == REG_MAX_AGE)
                age_limit = longint'($signed(value[47:0]));
            else if (idx == REG_STREAM_CAP)
                stream_cap = value[31:0];
            else if (idx == REG_TOTAL_CAP)
                total_cap = value[31:0];
        endfunction

        function void push(kind_t k, int i, bit lst);
            cache_word_t w;
            w.kind = k;
            w.last = lst;
            if (i >= 0) begin
                w.stream = ent_stream[i]; w.seq = ent_seq[i];
                w.bytes = ent_bytes[i];   w.keyframe = ent_kf[i];
            end
            else begin
                w.stream = 0; w.seq = 0; w.bytes = 0; w.keyframe = 0;
            end
            pending = {pending, w};
        endfunction

        function bit [31:0] sub_floor(bit [31:0] a, bit [31:0] b);
            return (b >= a) ? 32'd0 : a - b;
        endfunction

        function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void remove(int i);
            stream_sum[ent_stream[i]] = sub_floor(stream_sum[ent_stream[i]], ent_bytes[i]);
            total_sum = sub_floor(total_sum, ent_bytes[i]);
            valid[i] = 0;
        endfunction

        function void evict(int i);
            push(KIND_EVICT, i, 0);
            remove(i);
        endfunction

        function int newest_key(int s);
            int best;
            best = -1;
            for (int i = 0; i < FRAMES; i++) begin
                if (!valid[i] || ent_stream[i] != s || !ent_kf[i]) continue;
                if (best < 0 || ent_order[i] > ent_order[best]) best = i;
            end
            return best;
        endfunction

        // oldest entry in scope, sparing each stream's newest keyframe if possible
        function int pick_victim(int scope);
            int lk [STREAMS];
            int oldest;
            int unprot;
            oldest = -1;
            unprot = -1;
            for (int s = 0; s < STREAMS; s++) lk[s] = newest_key(s);
            for (int i = 0; i < FRAMES; i++) begin
                if (!valid[i]) continue;
                if (scope < 3 && ent_stream[i] != scope) continue;
                if (oldest < 0 || ent_order[i] < ent_order[oldest]) oldest = i;
                if (i != lk[ent_stream[i]] && (unprot < 0 || ent_order[i] < ent_order[unprot]))
                    unprot = i;
            end
            return (unprot >= 0) ? unprot : oldest;
        endfunction

        // lowest (stream, seq) among picked entries
        function int lowest_key();
            int best;
            best = -1;
            for (int i = 0; i < FRAMES; i++) begin
                if (!valid[i] || !pick[i]) continue;
                if (best < 0 || ent_stream[i] < ent_stream[best] ||
                    (ent_stream[i] == ent_stream[best] && ent_seq[i] < ent_seq[best]))
                    best = i;
            end
            return best;
        endfunction

        function int lookup(int s, bit [31:0] seq);
            for (int i = 0; i < FRAMES; i++)
                if (valid[i] && ent_stream[i] == s && ent_seq[i] == seq) return i;
            return -1;
        endfunction

        function void apply_caps();
            bit any;
            int c;
            foreach (pick[i]) pick[i] = 1;
            do begin
                any = 0;
                for (int s = 0; s < STREAMS; s++) begin
                    c = pick_victim(s);
                    while ((stream_cap == 0 || stream_sum[s] > stream_cap) && c >= 0) begin
                        evict(c); any = 1;
                        c = pick_victim(s);
                    end
                end
                if (total_cap > 0) begin
                    c = pick_victim(3);
                    while (total_sum > total_cap && c >= 0) begin
                        evict(c); any = 1;
                        c = pick_victim(3);
                    end
                end
                else begin
                    c = lowest_key();
                    while (c >= 0) begin
                        evict(c); any = 1;
                        c = lowest_key();
                    end
                end
            end while (any);
        endfunction

        // note an accepted command and queue the words it causes
        function void note_command(logic c, logic [1:0] s, logic [31:0] seq,
                                   logic [31:0] bytes, logic kf, logic [62:0] tnow);
            int i;
            bit [63:0] t;
            t = {1'b0, tnow};
            if (c == CMD_LOOKUP) begin
                i = (s < 3) ? lookup(s, seq) : -1;
                if (i >= 0) push(KIND_HIT, i, 1);
                else push(KIND_MISS, -1, 1);
                return;
            end
            if (s < 3) begin
                i = lookup(s, seq);
                if (i >= 0) remove(i);
                i = 0;
                while (i < FRAMES && valid[i]) i++;
                if (i >= FRAMES) begin
                    evict(pick_victim(3));
                    i = 0;
                    while (i < FRAMES && valid[i]) i++;
                end
                valid[i] = 1; ent_stream[i] = s; ent_seq[i] = seq;
                ent_bytes[i] = bytes; ent_kf[i] = kf; ent_stamp[i] = t;
                ent_order[i] = order_ctr;
                order_ctr++;
                stream_sum[s] = add_sat(stream_sum[s], bytes);
                total_sum = add_sat(total_sum, bytes);
                // expire, reported in key order; a future stamp never expires
                if (age_limit >= 0) begin
                    for (int j = 0; j < FRAMES; j++)
                        pick[j] = valid[j] && t >= ent_stamp[j] &&
                                  (t - ent_stamp[j]) > 64'(age_limit);
                    i = lowest_key();
                    while (i >= 0) begin
                        evict(i);
                        i = lowest_key();
                    end
                end
                apply_caps();
            end
            push(KIND_DONE, -1, 1);
        endfunction

        function void check_word(cache_word_t got);
            cache_word_t exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word kind=%0d stream=%0d seq=%h bytes=%h kf=%b last=%b",
                         $time, got.kind, got.stream, got.seq, got.bytes, got.keyframe,
                         got.last);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (exp_w.kind !== got.kind || exp_w.stream !== got.stream ||
                exp_w.seq !== got.seq || exp_w.bytes !== got.bytes ||
                exp_w.keyframe !== got.keyframe || exp_w.last !== got.last) begin
                $display("%0t: mismatch expected kind=%0d stream=%0d seq=%h bytes=%h kf=%b last=%b",
                         $time, exp_w.kind, exp_w.stream, exp_w.seq, exp_w.bytes,
                         exp_w.keyframe, exp_w.last);
                $display("%0t:          actual   kind=%0d stream=%0d seq=%h bytes=%h kf=%b last=%b",
                         $time, got.kind, got.stream, got.seq, got.bytes, got.keyframe,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 60000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              cmd = CMD_STORE;
    logic [1:0]        stream = '0;
    logic [31:0]       frame_seq = '0;
    logic [31:0]       frame_bytes = '0;
    logic              is_keyframe = 1'b0;
    logic [62:0]       now = '0;
    logic              strobe;
    logic [1:0]        kind;
    logic [1:0]        out_stream;
    logic [31:0]       out_seq;
    logic [31:0]       out_bytes;
    logic              out_keyframe;
    logic              last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    frame_table_predictor frames_expected = new();
    int                   stall_cycles = 0;
    bit                   calm = 0;      // set to hold the sender free of gaps
    logic [62:0]          clock_ns = 63'd1000;

    frame_repair_cache_eviction dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .cmd(cmd), .stream(stream),
        .frame_seq(frame_seq), .frame_bytes(frame_bytes),
        .is_keyframe(is_keyframe), .now(now),
        .strobe(strobe), .kind(kind), .out_stream(out_stream), .out_seq(out_seq),
        .out_bytes(out_bytes), .out_keyframe(out_keyframe), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Check every result word at the edge that ends its cycle, and watch for
    // a hang: count edges at which neither a command nor a word moves.
    always @(posedge clk)
    begin
        cache_word_t w;
        if (rst_n) begin
            if (strobe) begin
                w.kind = kind_t'(kind); w.stream = out_stream; w.seq = out_seq;
                w.bytes = out_bytes; w.keyframe = out_keyframe; w.last = last;
                frames_expected.check_word(w);
            end
            if (strobe || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Present a command and hold it until the block takes it. Start is left
    // high so back-to-back commands need no second assignment in one step.
    task automatic send_word(logic c, logic [1:0] s, logic [31:0] seq,
                             logic [31:0] bytes, logic kf, logic [62:0] tnow);
        cmd <= c; stream <= s; frame_seq <= seq; frame_bytes <= bytes;
        is_keyframe <= kf; now <= tnow; start <= 1'b1;
        do @(posedge clk); while (busy);
        frames_expected.note_command(c, s, seq, bytes, kf, tnow);
        // idle now and then, except in the calm stretch
        if (!calm && $urandom_range(0, 99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drain the block, then write one register through a setup and an access cycle.
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (frames_expected.pending.size() != 0 || busy) @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000}); pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        frames_expected.set_reg(idx, value);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_caps(logic [47:0] age, logic [31:0] scap, logic [31:0] tcap);
        write_reg(REG_MAX_AGE, {16'h0, age});
        write_reg(REG_STREAM_CAP, {32'h0, scap});
        write_reg(REG_TOTAL_CAP, {32'h0, tcap});
    endtask

    // Random command: mostly stores to a small key pool so keys repeat and
    // the table fills; time mostly advances, sometimes jumps anywhere.
    task automatic random_word();
        logic [1:0]  s;
        logic [31:0] seq;
        logic [31:0] bytes;
        logic [62:0] tnow;
        s = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        seq = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 7));
        bytes = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 2000));
        if ($urandom_range(0, 14) == 0)
            tnow = 63'({$urandom(), $urandom()});
        else begin
            clock_ns = clock_ns + 63'($urandom_range(0, 600));
            tnow = clock_ns;
        end
        send_word(($urandom_range(0, 9) < 7) ? CMD_STORE : CMD_LOOKUP, s, seq, bytes,
                  1'($urandom_range(0, 1)), tnow);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: large budgets and no expiry, so the table fills up.
        set_caps(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_STORE, 2'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, 63'h0);
        send_word(CMD_STORE, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(CMD_LOOKUP, 2'd0, 32'hFFFF_FFFF, 32'h0, 1'b0, 63'h0);
        send_word(CMD_LOOKUP, 2'd2, 32'h5, 32'h0, 1'b0, 63'h0);
        send_word(CMD_STORE, 2'd3, 32'h1, 32'h10, 1'b1, 63'h5);
        send_word(CMD_LOOKUP, 2'd3, 32'h1, 32'h0, 1'b0, 63'h0);
        // same key again: old entry dropped without report
        send_word(CMD_STORE, 2'd0, 32'h0, 32'h0, 1'b0, 63'h10);
        send_word(CMD_LOOKUP, 2'd0, 32'h0, 32'h0, 1'b0, 63'h0);
        // fill past 16 entries to force full-table evictions
        calm = 1;
        for (int k = 0; k < 17; k++)
            send_word(CMD_STORE, 2'(k % 3), 32'(100 + k), 32'(k * 7), 1'(k % 4 == 0),
                      63'(200 + k));
        calm = 0;

        // Expiry with a small age limit and tight caps, then a zero age limit, then
        // the largest age with a zero stream cap, then a zero total cap without expiry.
        set_caps(48'd500, 32'd3000, 32'd6000);
        repeat (21) random_word();
        set_caps(48'd0, 32'd1500, 32'd2500);
        calm = 1;
        repeat (21) random_word();
        calm = 0;
        set_caps(48'h7FFF_FFFF_FFFF, 32'd0, 32'd5000);
        repeat (21) random_word();
        set_caps(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        repeat (21) random_word();
        set_caps(48'd2000, 32'd4000, 32'hFFFF_FFFF);
        repeat (21) random_word();

        start <= 1'b0;
        while (frames_expected.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (frames_expected.errors == 0 && frames_expected.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
